// ----- design/yrc_pkg.sv -----
// Shared types, register indexes, codes and color coefficients of the YUV 4:2:0 to RGB24 converter.
package yrc_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 2048;
   localparam int MAX_HEIGHT_DEFAULT = 2048;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 12;
   localparam int OFFSET_W   = 24;
   localparam int ACC_W      = 23;

   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ORIENTATION  = 2'd2;

   localparam logic [CSR_DATA_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [CSR_DATA_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

   localparam logic [1:0] ORIENT_NORMAL = 2'd0;
   localparam logic [1:0] ORIENT_ROTATE = 2'd1;
   localparam logic [1:0] ORIENT_FLIP   = 2'd2;

   localparam logic [1:0] LAST_PIXEL = 2'd3;

   // Q12 coefficients: 2.032, -0.394, -0.581 and 1.140 rounded to 1/4096.
   localparam logic signed [ACC_W-1:0] COEF_BU  = 23'sd8323;
   localparam logic signed [ACC_W-1:0] COEF_GU  = -23'sd1614;
   localparam logic signed [ACC_W-1:0] COEF_GV  = -23'sd2380;
   localparam logic signed [ACC_W-1:0] COEF_RV  = 23'sd4669;
   localparam logic signed [ACC_W-1:0] Q12_HALF = 23'sd2048;

   typedef struct packed {
      logic [7:0] luma_top_left;
      logic [7:0] luma_top_right;
      logic [7:0] luma_bottom_left;
      logic [7:0] luma_bottom_right;
      logic [7:0] chroma_u;
      logic [7:0] chroma_v;
   } req_type;

   typedef struct packed {
      logic [7:0]          blue;
      logic [7:0]          green;
      logic [7:0]          red;
      logic [OFFSET_W-1:0] byte_offset;
      logic                last_of_group;
   } rsp_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] bu;
      logic signed [ACC_W-1:0] gu;
      logic signed [ACC_W-1:0] gv;
      logic signed [ACC_W-1:0] rv;
   } chroma_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } color_type;

   typedef struct packed {
      color_type [3:0]                 color;
      logic      [3:0][OFFSET_W-1:0]   offset;
   } group_type;

endpackage

// ----- design/yrc_lane.sv -----
// One color lane: adds luma to the shared chroma terms and clamps blue, green and red.
module yrc_lane (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [7:0]            luma,
   input  yrc_pkg::chroma_type   chroma,
   output yrc_pkg::color_type    color
);

   logic signed [yrc_pkg::ACC_W-1:0] y_q12;
   logic signed [yrc_pkg::ACC_W-1:0] acc_b;
   logic signed [yrc_pkg::ACC_W-1:0] acc_g;
   logic signed [yrc_pkg::ACC_W-1:0] acc_r;
   yrc_pkg::color_type               color_ff;
   yrc_pkg::color_type               color_in;

   // Negative sums go to zero; anything at or above 256.0 saturates.
   function automatic logic [7:0] clamp_q12(input logic signed [yrc_pkg::ACC_W-1:0] acc);
      if (acc[yrc_pkg::ACC_W-1]) begin
         return 8'h00;
      end else if (|acc[yrc_pkg::ACC_W-2:20]) begin
         return 8'hFF;
      end else begin
         return acc[19:12];
      end
   endfunction

   always_comb begin
      y_q12 = $signed({3'b000, luma, 12'h000});
      acc_b = y_q12 + $signed(chroma.bu) + yrc_pkg::Q12_HALF;
      acc_g = y_q12 + $signed(chroma.gu) + $signed(chroma.gv) + yrc_pkg::Q12_HALF;
      acc_r = y_q12 + $signed(chroma.rv) + yrc_pkg::Q12_HALF;
      color_in.blue  = clamp_q12(acc_b);
      color_in.green = clamp_q12(acc_g);
      color_in.red   = clamp_q12(acc_r);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         color_ff <= color_in;
      end
   end

   assign color = color_ff;

endmodule

// ----- design/yrc_offset.sv -----
// Byte offset unit: one shared multiply, then the four pixel offsets of a group.
module yrc_offset #(
   parameter int MAX_WIDTH  = yrc_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = yrc_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   en_product,
   input  logic                                   en_offset,
   input  logic [1:0]                             orientation,
   input  logic [$clog2(MAX_WIDTH/2+1):0]         width,
   input  logic [$clog2(MAX_HEIGHT/2+1):0]        height,
   input  logic [((MAX_WIDTH/2>1)?$clog2(MAX_WIDTH/2):1)-1:0]   column_pair,
   input  logic [((MAX_HEIGHT/2>1)?$clog2(MAX_HEIGHT/2):1)-1:0] row_pair,
   output logic [3:0][yrc_pkg::OFFSET_W-1:0]      offset
);

   localparam int WW  = $clog2(MAX_WIDTH/2+1) + 1;
   localparam int HW  = $clog2(MAX_HEIGHT/2+1) + 1;
   localparam int MW  = (WW > HW) ? WW : HW;
   localparam int OW  = yrc_pkg::OFFSET_W;

   logic [MW-1:0]   mul_a;
   logic [MW-1:0]   mul_b;
   logic [OW-1:0]   add_term;
   logic [OW-1:0]   step_right;
   logic [OW-1:0]   step_down;
   logic [OW-1:0]   width_x3;
   logic [OW-1:0]   height_x3;
   logic [OW-1:0]   column_x6;
   logic [OW-1:0]   row_x6;
   logic [OW-1:0]   col24;
   logic [OW-1:0]   row24;

   logic [2*MW-1:0] product_ff;
   logic [OW-1:0]   add_ff;
   logic [OW-1:0]   right_ff;
   logic [OW-1:0]   down_ff;
   logic [OW-1:0]   both_ff;

   logic [OW-1:0]   product24;
   logic [OW-1:0]   top;
   logic [3:0][OW-1:0] offset_ff;
   logic [3:0][OW-1:0] offset_in;

   always_comb begin
      width_x3   = OW'(width) + (OW'(width) << 1);
      height_x3  = OW'(height) + (OW'(height) << 1);
      col24      = OW'(column_pair);
      row24      = OW'(row_pair);
      column_x6  = (col24 << 2) + (col24 << 1);
      row_x6     = (row24 << 2) + (row24 << 1);
      // Each layout is 3 * (a * b) + add, with its own right and down strides.
      unique case (orientation)
         yrc_pkg::ORIENT_ROTATE: begin
            mul_a      = MW'(height);
            mul_b      = MW'({column_pair, 1'b0});
            add_term   = row_x6;
            step_right = height_x3;
            step_down  = OW'(3);
         end
         yrc_pkg::ORIENT_FLIP: begin
            mul_a      = MW'(width);
            mul_b      = MW'(height) - MW'(1) - MW'({row_pair, 1'b0});
            add_term   = column_x6;
            step_right = OW'(3);
            step_down  = '0 - width_x3;
         end
         default: begin
            mul_a      = MW'(width);
            mul_b      = MW'({row_pair, 1'b0});
            add_term   = column_x6;
            step_right = OW'(3);
            step_down  = width_x3;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en_product) begin
         product_ff <= mul_a * mul_b;
         add_ff     <= add_term;
         right_ff   <= step_right;
         down_ff    <= step_down;
         both_ff    <= step_right + step_down;
      end
   end

   always_comb begin
      product24    = OW'(product_ff);
      top          = product24 + (product24 << 1) + add_ff;
      offset_in[0] = top;
      offset_in[1] = top + right_ff;
      offset_in[2] = top + down_ff;
      offset_in[3] = top + both_ff;
   end

   always_ff @(posedge clock) begin
      if (en_offset) begin
         offset_ff <= offset_in;
      end
   end

   assign offset = offset_ff;

endmodule

// ----- design/yrc_merge.sv -----
// Merge stage: holds one finished group and sends its four pixels one beat at a time.
module yrc_merge (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_valid,
   input  yrc_pkg::group_type  group,
   output logic                can_load,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output yrc_pkg::rsp_type    rsp_data
);

   logic                valid_ff;
   logic                valid_in;
   logic [1:0]          idx_ff;
   logic [1:0]          idx_in;
   yrc_pkg::group_type  group_ff;

   assign can_load = !valid_ff || (rsp_ready && (idx_ff == yrc_pkg::LAST_PIXEL));

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load_valid && can_load) begin
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (valid_ff && rsp_ready) begin
         idx_in = idx_ff + 2'd1;
         if (idx_ff == yrc_pkg::LAST_PIXEL) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (can_load) begin
         group_ff <= group;
      end
   end

   always_comb begin
      rsp_data.blue          = group_ff.color[idx_ff].blue;
      rsp_data.green         = group_ff.color[idx_ff].green;
      rsp_data.red           = group_ff.color[idx_ff].red;
      rsp_data.byte_offset   = group_ff.offset[idx_ff];
      rsp_data.last_of_group = (idx_ff == yrc_pkg::LAST_PIXEL);
   end

   assign rsp_valid = valid_ff;

endmodule

// ----- design/yuv420_to_rgb24_converter.sv -----
// Top level of the YUV 4:2:0 to RGB24 converter: registers, group counters, pipeline and lanes.
//
// Each request beat carries one 2x2 luma group and its shared U and V samples, groups in
// raster order; each group gives four response beats (top-left, top-right, bottom-left,
// bottom-right) with BT.601 style Q12 color, clamped to 0..255, and the byte offset of the
// pixel in the RGB24 frame for the selected orientation, last_of_group marking the fourth.
// Group throughput is set by the one-pixel-per-beat response port, and so by its stalls;
// a new group is taken while the previous one is still being sent. The first pixel of a
// group is valid once it has passed the registered product stage, lane stage and merge
// buffer. Writing frame_width or frame_height restarts the frame.
module yuv420_to_rgb24_converter #(
   parameter int MAX_WIDTH  = yrc_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = yrc_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  yrc_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output yrc_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [yrc_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [yrc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // Group counts per row and per column, and the widths that follow from them.
   localparam int MAXPW = MAX_WIDTH / 2;
   localparam int MAXPH = MAX_HEIGHT / 2;
   localparam int PWW   = $clog2(MAXPW + 1);
   localparam int PHW   = $clog2(MAXPH + 1);
   localparam int CPW   = (MAXPW > 1) ? $clog2(MAXPW) : 1;
   localparam int RPW   = (MAXPH > 1) ? $clog2(MAXPH) : 1;
   localparam int CIW   = PWW + 1;
   localparam int RIW   = PHW + 1;

   logic [yrc_pkg::CSR_DATA_W-1:0] frame_width_ff;
   logic [yrc_pkg::CSR_DATA_W-1:0] frame_width_in;
   logic [yrc_pkg::CSR_DATA_W-1:0] frame_height_ff;
   logic [yrc_pkg::CSR_DATA_W-1:0] frame_height_in;
   logic [1:0]                     orientation_ff;
   logic [1:0]                     orientation_in;
   logic [CPW-1:0]                 column_pair_ff;
   logic [CPW-1:0]                 column_pair_in;
   logic [RPW-1:0]                 row_pair_ff;
   logic [RPW-1:0]                 row_pair_in;

   logic [13:0]    width_half;
   logic [13:0]    height_half;
   logic [PWW-1:0] width_pairs;
   logic [PHW-1:0] height_pairs;
   logic [PWW:0]   width_eff;
   logic [PHW:0]   height_eff;

   logic           position_wrap;
   logic [CPW-1:0] column_now;
   logic [RPW-1:0] row_now;
   logic [CIW-1:0] column_inc;
   logic [RIW-1:0] row_inc;
   logic [CPW-1:0] column_next;
   logic [RPW-1:0] row_next;

   logic                  req_accept;
   logic                  s2_free;
   logic                  s3_free;
   logic                  s2_valid_ff;
   logic                  s3_valid_ff;
   logic                  merge_can_load;

   logic signed [9:0]                 chroma_u_s;
   logic signed [9:0]                 chroma_v_s;
   logic signed [yrc_pkg::ACC_W-1:0]  u_ext;
   logic signed [yrc_pkg::ACC_W-1:0]  v_ext;
   yrc_pkg::chroma_type               chroma_in;
   yrc_pkg::chroma_type               chroma_ff;
   logic [3:0][7:0]                   luma_in;
   logic [3:0][7:0]                   luma_ff;

   yrc_pkg::group_type                group;

   // Effective dimensions: even, and clamped between one group and the maximum.
   always_comb begin
      width_half  = 14'(frame_width_ff[yrc_pkg::CSR_DATA_W-1:1]);
      height_half = 14'(frame_height_ff[yrc_pkg::CSR_DATA_W-1:1]);
      if (width_half == 14'd0) begin
         width_pairs = PWW'(1);
      end else if (width_half > 14'(MAXPW)) begin
         width_pairs = PWW'(MAXPW);
      end else begin
         width_pairs = width_half[PWW-1:0];
      end
      if (height_half == 14'd0) begin
         height_pairs = PHW'(1);
      end else if (height_half > 14'(MAXPH)) begin
         height_pairs = PHW'(MAXPH);
      end else begin
         height_pairs = height_half[PHW-1:0];
      end
      width_eff  = {width_pairs, 1'b0};
      height_eff = {height_pairs, 1'b0};
   end

   // Position of the group being accepted and the position of the one after it.
   always_comb begin
      position_wrap = (CIW'(column_pair_ff) >= CIW'(width_pairs)) ||
                      (RIW'(row_pair_ff) >= RIW'(height_pairs));
      column_now    = position_wrap ? '0 : column_pair_ff;
      row_now       = position_wrap ? '0 : row_pair_ff;
      column_inc    = CIW'(column_now) + CIW'(1);
      row_inc       = RIW'(row_now) + RIW'(1);
      if (column_inc >= CIW'(width_pairs)) begin
         column_next = '0;
         row_next    = (row_inc >= RIW'(height_pairs)) ? '0 : row_inc[RPW-1:0];
      end else begin
         column_next = column_inc[CPW-1:0];
         row_next    = row_now;
      end
   end

   // Register writes; a dimension write sends the counters back to the frame start.
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      orientation_in  = orientation_ff;
      column_pair_in  = column_pair_ff;
      row_pair_in     = row_pair_ff;
      if (req_accept) begin
         column_pair_in = column_next;
         row_pair_in    = row_next;
      end
      if (csr_we) begin
         unique case (csr_addr)
            yrc_pkg::CSR_FRAME_WIDTH: begin
               frame_width_in = csr_wdata;
               column_pair_in = '0;
               row_pair_in    = '0;
            end
            yrc_pkg::CSR_FRAME_HEIGHT: begin
               frame_height_in = csr_wdata;
               column_pair_in  = '0;
               row_pair_in     = '0;
            end
            yrc_pkg::CSR_ORIENTATION: begin
               orientation_in = csr_wdata[1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= yrc_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= yrc_pkg::FRAME_HEIGHT_RESET;
         orientation_ff  <= yrc_pkg::ORIENT_NORMAL;
         column_pair_ff  <= '0;
         row_pair_ff     <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         orientation_ff  <= orientation_in;
         column_pair_ff  <= column_pair_in;
         row_pair_ff     <= row_pair_in;
      end
   end

   // Pipeline flow: each stage loads when it is empty or when its contents move on.
   assign s3_free    = !s3_valid_ff || merge_can_load;
   assign s2_free    = !s2_valid_ff || s3_free;
   assign req_ready  = s2_free;
   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s2_free) begin
            s2_valid_ff <= req_valid;
         end
         if (s3_free) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // Chroma products are shared by the four lanes of a group.
   always_comb begin
      chroma_u_s   = $signed({2'b00, req_data.chroma_u}) - 10'sd128;
      chroma_v_s   = $signed({2'b00, req_data.chroma_v}) - 10'sd128;
      u_ext        = yrc_pkg::ACC_W'(chroma_u_s);
      v_ext        = yrc_pkg::ACC_W'(chroma_v_s);
      chroma_in.bu = yrc_pkg::COEF_BU * u_ext;
      chroma_in.gu = yrc_pkg::COEF_GU * u_ext;
      chroma_in.gv = yrc_pkg::COEF_GV * v_ext;
      chroma_in.rv = yrc_pkg::COEF_RV * v_ext;
      luma_in[0]   = req_data.luma_top_left;
      luma_in[1]   = req_data.luma_top_right;
      luma_in[2]   = req_data.luma_bottom_left;
      luma_in[3]   = req_data.luma_bottom_right;
   end

   always_ff @(posedge clock) begin
      if (s2_free) begin
         chroma_ff <= chroma_in;
         luma_ff   <= luma_in;
      end
   end

   // Four color lanes, one per pixel of the group.
   for (genvar k = 0; k < 4; k++) begin : g_lane
      yrc_lane u_lane (
         .clock  (clock),
         .enable (s3_free),
         .luma   (luma_ff[k]),
         .chroma (chroma_ff),
         .color  (group.color[k])
      );
   end

   yrc_offset #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_offset (
      .clock       (clock),
      .en_product  (s2_free),
      .en_offset   (s3_free),
      .orientation (orientation_ff),
      .width       (width_eff),
      .height      (height_eff),
      .column_pair (column_now),
      .row_pair    (row_now),
      .offset      (group.offset)
   );

   yrc_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load_valid (s3_valid_ff),
      .group      (group),
      .can_load   (merge_can_load),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- design/yrc_checker.sv -----
// Port-level checker of the converter and the bind that attaches it.
module yrc_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  yrc_pkg::rsp_type                  rsp_data
);

   logic       req_beat;
   logic       rsp_beat;
   logic [1:0] beat_count_ff;
   logic [7:0] pending_ff;

   assign req_beat      = req_valid && req_ready;
   assign rsp_beat      = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_count_ff <= '0;
         pending_ff    <= '0;
      end else begin
         if (rsp_beat) begin
            beat_count_ff <= beat_count_ff + 2'd1;
         end
         pending_ff <= pending_ff + (req_beat ? 8'd4 : 8'd0) - (rsp_beat ? 8'd1 : 8'd0);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat dropped or changed while stalled");

   a_last_marks_fourth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_of_group == (beat_count_ff == yrc_pkg::LAST_PIXEL)))
      else $error("last_of_group not on the fourth beat of a group");

   a_no_extra_pixels: assert property (@(posedge clock) disable iff (reset)
      rsp_beat |-> (pending_ff != 8'd0))
      else $error("more response beats than four per accepted group");

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind yuv420_to_rgb24_converter yrc_checker u_chk (.*);

// ----- dv/tb_top.sv -----
// Self-checking testbench for the YUV 4:2:0 to RGB24 converter with a built-in pixel scoreboard.
`timescale 1ns / 1ps

module tb_top;

   // Register index past the end of the map and the orientation code with no layout of its
   // own. The block ignores the first and treats the second as the normal layout.
   localparam logic [yrc_pkg::CSR_ADDR_W-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam logic [1:0]                     ORIENT_UNUSED    = 2'd3;

   // Number of random groups to push after the directed part.
   localparam int RANDOM_GROUPS = 330;

   // The watchdog gives up after this many cycles in which no beat moves on either channel.
   // The longest legal quiet stretch is a phase change (drain, register writes, sender gap
   // and pipeline fill), which stays well under this limit.
   localparam int QUIET_LIMIT = 400;

   // Cycles to keep watching after the last expected pixel, so that a stray extra beat
   // coming out of the pipeline is still caught.
   localparam int TAIL_CYCLES = 12;

   // The scoreboard keeps its own copy of the registers and of the group position counters.
   // Each accepted group is turned into its four expected pixels right away, and each
   // pixel beat coming out of the block is compared with the oldest one still waiting.
   class pixel_scoreboard;
      yrc_pkg::rsp_type expected_pixels[$];
      int               errors;
      logic [11:0]      width_reg;
      logic [11:0]      height_reg;
      logic [1:0]       orient_reg;
      int unsigned      col_pair;
      int unsigned      row_pair;

      function new();
         width_reg  = yrc_pkg::FRAME_WIDTH_RESET;
         height_reg = yrc_pkg::FRAME_HEIGHT_RESET;
         orient_reg = yrc_pkg::ORIENT_NORMAL;
         col_pair   = 0;
         row_pair   = 0;
         errors     = 0;
      endfunction

      // Writing either dimension restarts the frame; orientation leaves the counters alone.
      function void write_reg(logic [yrc_pkg::CSR_ADDR_W-1:0] addr,
                              logic [yrc_pkg::CSR_DATA_W-1:0] data);
         case (addr)
            yrc_pkg::CSR_FRAME_WIDTH: begin
               width_reg = data;
               col_pair  = 0;
               row_pair  = 0;
            end
            yrc_pkg::CSR_FRAME_HEIGHT: begin
               height_reg = data;
               col_pair   = 0;
               row_pair   = 0;
            end
            yrc_pkg::CSR_ORIENTATION: begin
               orient_reg = data[1:0];
            end
            default: begin
            end
         endcase
      endfunction

      // Groups along one dimension: odd sizes round down, and the count is held to 1..max/2.
      function int unsigned pair_count(logic [11:0] dim, int unsigned max_dim);
         int unsigned pairs;
         pairs = dim >> 1;
         if (pairs == 0) pairs = 1;
         if (pairs > max_dim / 2) pairs = max_dim / 2;
         return pairs;
      endfunction

      // A negative sum gives 0; otherwise it is floored to Q0 and held at 255.
      function logic [7:0] clamp_channel(int acc);
         int level;
         if (acc < 0) return 8'd0;
         level = acc >>> 12;
         if (level > 255) level = 255;
         return 8'(level);
      endfunction

      function void note_group(yrc_pkg::req_type grp);
         int unsigned      wp, hp, w, h, base;
         int unsigned      off[4];
         int               u, v, cb, cg, cr, y;
         logic [7:0]       luma[4];
         yrc_pkg::rsp_type px;
         wp = pair_count(width_reg, yrc_pkg::MAX_WIDTH_DEFAULT);
         hp = pair_count(height_reg, yrc_pkg::MAX_HEIGHT_DEFAULT);
         w  = wp * 2;
         h  = hp * 2;
         u  = int'(grp.chroma_u) - 128;
         v  = int'(grp.chroma_v) - 128;
         cb = int'(yrc_pkg::COEF_BU) * u + int'(yrc_pkg::Q12_HALF);
         cg = int'(yrc_pkg::COEF_GU) * u + int'(yrc_pkg::COEF_GV) * v
              + int'(yrc_pkg::Q12_HALF);
         cr = int'(yrc_pkg::COEF_RV) * v + int'(yrc_pkg::Q12_HALF);
         luma[0] = grp.luma_top_left;
         luma[1] = grp.luma_top_right;
         luma[2] = grp.luma_bottom_left;
         luma[3] = grp.luma_bottom_right;

         // A shrunken frame can leave the counters past its end; they then restart at zero.
         if (col_pair >= wp || row_pair >= hp) begin
            col_pair = 0;
            row_pair = 0;
         end

         case (orient_reg)
            yrc_pkg::ORIENT_ROTATE: begin
               base   = row_pair * 6 + col_pair * 6 * h;
               off[0] = base;
               off[1] = base + 3 * h;
               off[2] = base + 3;
               off[3] = base + 3 + 3 * h;
            end
            yrc_pkg::ORIENT_FLIP: begin
               base   = w * (h - 1) * 3 - row_pair * 6 * w + col_pair * 6;
               off[0] = base;
               off[1] = base + 3;
               off[2] = base - 3 * w;
               off[3] = base - 3 * w + 3;
            end
            default: begin
               base   = (row_pair * 2 * w + col_pair * 2) * 3;
               off[0] = base;
               off[1] = base + 3;
               off[2] = base + 3 * w;
               off[3] = base + 3 * w + 3;
            end
         endcase

         for (int k = 0; k < 4; k++) begin
            y                = int'(luma[k]) << 12;
            px.blue          = clamp_channel(y + cb);
            px.green         = clamp_channel(y + cg);
            px.red           = clamp_channel(y + cr);
            px.byte_offset   = yrc_pkg::OFFSET_W'(off[k]);
            px.last_of_group = (k == int'(yrc_pkg::LAST_PIXEL));
            expected_pixels.push_back(px);
         end

         col_pair++;
         if (col_pair >= wp) begin
            col_pair = 0;
            row_pair++;
            if (row_pair >= hp) row_pair = 0;
         end
      endfunction

      function void check_pixel(yrc_pkg::rsp_type got);
         yrc_pkg::rsp_type want;
         if (expected_pixels.size() == 0) begin
            $error("pixel beat with nothing expected: %h", got);
            errors++;
            return;
         end
         want = expected_pixels.pop_front();
         if (got.blue != want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, got.blue);
            errors++;
         end
         if (got.green != want.green) begin
            $error("green: expected %0d, got %0d", want.green, got.green);
            errors++;
         end
         if (got.red != want.red) begin
            $error("red: expected %0d, got %0d", want.red, got.red);
            errors++;
         end
         if (got.byte_offset != want.byte_offset) begin
            $error("byte_offset: expected %0d, got %0d", want.byte_offset, got.byte_offset);
            errors++;
         end
         if (got.last_of_group != want.last_of_group) begin
            $error("last_of_group: expected %0d, got %0d", want.last_of_group,
                   got.last_of_group);
            errors++;
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   // Every input of the block starts at a known value at time zero.
   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   yrc_pkg::req_type               req_data  = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   yrc_pkg::rsp_type               rsp_data;
   logic                           csr_we    = 1'b0;
   logic [yrc_pkg::CSR_ADDR_W-1:0] csr_addr  = '0;
   logic [yrc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // When set, neither side inserts gaps or stalls, so the block runs at its full rate.
   bit                    no_idle   = 1'b0;
   int                    quiet_cycles = 0;
   pixel_scoreboard       sb;

   yuv420_to_rgb24_converter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // A 4 ns clock, low for the first half of the period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // All sampling happens here at the rising edge. Beats that move at this edge are handed
   // to the scoreboard, and so are register writes. The pixel check comes first: a pixel
   // leaving at this edge always belongs to a group accepted at an earlier edge.
   // The same block runs the watchdog over cycles in which nothing moves.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready) sb.check_pixel(rsp_data);
         if (req_valid && req_ready) sb.note_group(req_data);
         if (csr_we) sb.write_reg(csr_addr, csr_wdata);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Receiver: before each pixel beat it holds ready low for a random number of cycles,
   // then keeps it high until a beat is taken. All changes happen at the falling edge.
   initial begin
      int stall;
      while (reset) @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Offers one group on the request channel. It is entered and left at a falling edge.
   // A random gap comes first; after that valid stays high with the payload held until
   // the beat is taken.
   task automatic send_group(input yrc_pkg::req_type grp);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = grp;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Stops the sender and waits for every expected pixel, then a few more cycles so the
   // pipeline is surely empty before a register is touched.
   task automatic wait_idle();
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic config_write(input logic [yrc_pkg::CSR_ADDR_W-1:0] addr,
                               input logic [yrc_pkg::CSR_DATA_W-1:0] data);
      csr_we    = 1'b1;
      csr_addr  = addr;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      @(negedge clock);
   endtask

   function automatic yrc_pkg::req_type make_group(input logic [7:0] tl, input logic [7:0] tr,
                                                   input logic [7:0] bl, input logic [7:0] br,
                                                   input logic [7:0] u, input logic [7:0] v);
      yrc_pkg::req_type grp;
      grp.luma_top_left     = tl;
      grp.luma_top_right    = tr;
      grp.luma_bottom_left  = bl;
      grp.luma_bottom_right = br;
      grp.chroma_u          = u;
      grp.chroma_v          = v;
      return grp;
   endfunction

   // Samples lean toward 0, 128 and 255 now and then, so the clamps at both ends and the
   // neutral chroma point come up often; the rest is uniform.
   function automatic logic [7:0] random_sample();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'd128;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic yrc_pkg::req_type random_group();
      return make_group(random_sample(), random_sample(), random_sample(),
                        random_sample(), random_sample(), random_sample());
   endfunction

   // Frame dimensions are mostly tiny so that the counters wrap often. Now and then the
   // maximum size, an oversized value or any 12-bit value comes up.
   function automatic logic [yrc_pkg::CSR_DATA_W-1:0] random_dim();
      case ($urandom_range(0, 9))
         0:       return yrc_pkg::CSR_DATA_W'(yrc_pkg::MAX_WIDTH_DEFAULT);
         1:       return '1;
         2:       return yrc_pkg::CSR_DATA_W'($urandom_range(0, 4095));
         default: return yrc_pkg::CSR_DATA_W'($urandom_range(0, 24));
      endcase
   endfunction

   initial begin
      int random_sent;
      int phase;
      int phase_len;
      int pause_at;
      random_sent = 0;
      phase       = 0;
      sb          = new();

      // Synchronous reset, asserted from time zero and released at a falling edge.
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed colors in the reset frame: black and white extremes, full negative and
      // positive chroma on each axis, the neutral point, alternating bit patterns and a
      // chroma pair one step from neutral, where the rounding half matters.
      send_group(make_group(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_group(make_group(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_group(make_group(8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80));
      send_group(make_group(8'h00, 8'hFF, 8'h01, 8'hFE, 8'hFF, 8'h00));
      send_group(make_group(8'hFF, 8'h00, 8'hFE, 8'h01, 8'h00, 8'hFF));
      send_group(make_group(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55));
      send_group(make_group(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA));
      send_group(make_group(8'h10, 8'hEB, 8'h7F, 8'h81, 8'h81, 8'h7F));

      // Orientation changes alone must not restart the frame, so these groups carry on
      // from the position the groups above left behind.
      wait_idle();
      config_write(yrc_pkg::CSR_ORIENTATION, yrc_pkg::CSR_DATA_W'(yrc_pkg::ORIENT_ROTATE));
      repeat (2) send_group(random_group());
      wait_idle();
      config_write(yrc_pkg::CSR_ORIENTATION, yrc_pkg::CSR_DATA_W'(yrc_pkg::ORIENT_FLIP));
      repeat (2) send_group(random_group());
      wait_idle();
      config_write(yrc_pkg::CSR_ORIENTATION, yrc_pkg::CSR_DATA_W'(ORIENT_UNUSED));
      send_group(random_group());

      // A write past the register map must change nothing.
      wait_idle();
      config_write(CSR_UNUSED_INDEX, '1);
      send_group(random_group());

      // The smallest frame, one group, wraps on every group.
      wait_idle();
      config_write(yrc_pkg::CSR_FRAME_WIDTH, 12'd2);
      config_write(yrc_pkg::CSR_FRAME_HEIGHT, 12'd2);
      config_write(yrc_pkg::CSR_ORIENTATION, yrc_pkg::CSR_DATA_W'(yrc_pkg::ORIENT_FLIP));
      repeat (2) send_group(random_group());

      // Odd sizes round down to 4 by 2, two groups per frame.
      wait_idle();
      config_write(yrc_pkg::CSR_FRAME_WIDTH, 12'd5);
      config_write(yrc_pkg::CSR_FRAME_HEIGHT, 12'd3);
      config_write(yrc_pkg::CSR_ORIENTATION, yrc_pkg::CSR_DATA_W'(yrc_pkg::ORIENT_ROTATE));
      repeat (3) send_group(random_group());

      // Sizes below two are raised to two.
      wait_idle();
      config_write(yrc_pkg::CSR_FRAME_WIDTH, 12'd0);
      config_write(yrc_pkg::CSR_FRAME_HEIGHT, 12'd1);
      config_write(yrc_pkg::CSR_ORIENTATION, yrc_pkg::CSR_DATA_W'(yrc_pkg::ORIENT_NORMAL));
      repeat (2) send_group(random_group());

      // Oversized values are cut to the maximum frame; flipped, its first row holds the
      // largest offsets of all.
      wait_idle();
      config_write(yrc_pkg::CSR_FRAME_WIDTH, '1);
      config_write(yrc_pkg::CSR_FRAME_HEIGHT, '1);
      config_write(yrc_pkg::CSR_ORIENTATION, yrc_pkg::CSR_DATA_W'(yrc_pkg::ORIENT_FLIP));
      repeat (2) send_group(random_group());

      wait_idle();
      config_write(yrc_pkg::CSR_FRAME_WIDTH,
                   yrc_pkg::CSR_DATA_W'(yrc_pkg::MAX_WIDTH_DEFAULT));
      config_write(yrc_pkg::CSR_FRAME_HEIGHT,
                   yrc_pkg::CSR_DATA_W'(yrc_pkg::MAX_HEIGHT_DEFAULT));
      config_write(yrc_pkg::CSR_ORIENTATION, yrc_pkg::CSR_DATA_W'(yrc_pkg::ORIENT_ROTATE));
      repeat (2) send_group(random_group());

      // Random phases. Each one starts from an idle block with new register values; most
      // phases set new dimensions, the rest only change the orientation and so keep the
      // frame position. Some phases run with no gaps or stalls at all. In the first phase,
      // and now and then later, the sender stops in the middle until every pixel is out.
      while (random_sent < RANDOM_GROUPS) begin
         wait_idle();
         if ($urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 1) != 0) begin
               config_write(yrc_pkg::CSR_FRAME_WIDTH, random_dim());
               config_write(yrc_pkg::CSR_FRAME_HEIGHT, random_dim());
            end else begin
               config_write(yrc_pkg::CSR_FRAME_HEIGHT, random_dim());
               config_write(yrc_pkg::CSR_FRAME_WIDTH, random_dim());
            end
         end
         config_write(yrc_pkg::CSR_ORIENTATION,
                      yrc_pkg::CSR_DATA_W'($urandom_range(0, 4095)));
         if ($urandom_range(0, 7) == 0) begin
            config_write(CSR_UNUSED_INDEX, yrc_pkg::CSR_DATA_W'($urandom_range(0, 4095)));
         end
         no_idle   = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(8, 40);
         pause_at  = (phase == 0) ? phase_len / 2 : $urandom_range(1, 3 * phase_len);
         for (int i = 0; i < phase_len; i++) begin
            if (i == pause_at) wait_idle();
            send_group(random_group());
            random_sent++;
         end
         phase++;
      end

      // Drain, then keep watching for stray beats before the verdict.
      wait_idle();
      no_idle = 1'b0;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d expected pixels never arrived", sb.pending());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
